// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the fault rule checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/fault_chk_pkg.sv -----
// Types, constants and codes of the fault rule checker.
package fault_chk_pkg;

   // Rule table geometry.
   localparam int RULE_ENTRIES = 64;
   localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(RULE_ENTRIES + 1);

   // Request kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   // Write status codes.
   localparam logic WSTAT_OK   = 1'b0;
   localparam logic WSTAT_FULL = 1'b1;

   // Hash mixing: xorshift64 shift amounts and step codes.
   localparam int MIX_SHL_A = 13;
   localparam int MIX_SHR_B = 7;
   localparam int MIX_SHL_C = 17;
   localparam logic [1:0] MIX_STEP_A = 2'd0;
   localparam logic [1:0] MIX_STEP_B = 2'd1;
   localparam logic [1:0] MIX_STEP_C = 2'd2;

   // Modulo reduction of the hash, one hex digit per cycle.
   localparam int DICE_MOD    = 1000;
   localparam int DICE_W      = 10;
   localparam int DIGIT_W     = 4;
   localparam int REM_W       = DICE_W + DIGIT_W;
   localparam int HASH_W      = 64;
   localparam int MIX_DIGITS  = HASH_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(MIX_DIGITS);

   // Process id sits in the upper half of the task tag.
   localparam int PID_LSB = 32;

   typedef struct packed {
      logic               kind;
      logic [8:0]         call_id;
      logic [63:0]        now_ns;
      logic [63:0]        task_tag;
      logic               rule_present;
      logic [31:0]        rule_pid;
      logic [9:0]         rule_rate;
      logic signed [31:0] rule_code;
      logic [63:0]        rule_expiry_ns;
   } req_type;

   typedef struct packed {
      logic               fired;
      logic signed [31:0] error_code;
      logic [63:0]        event_time_ns;
      logic [31:0]        event_pid;
      logic [8:0]         event_call_id;
      logic [63:0]        fire_total;
      logic               write_status;
   } rsp_type;

   typedef struct packed {
      logic [8:0]         key;
      logic [31:0]        pid;
      logic [9:0]         rate;
      logic signed [31:0] code;
      logic [63:0]        expiry;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_QUAL,
      ST_MIX,
      ST_MOD,
      ST_DECIDE,
      ST_RESP
   } state_type;

endpackage

// ----- rtl/fault_injection_rule_checker.sv -----
// Fault rule checker: rule table, lookup walk, hash and modulo sequencer.
//
// Usage: a request transfer happens at a rising edge where start is high and
// busy is low; req_data carries the whole request. A write request (kind 0)
// stores, replaces or removes the rule of its call id. A check request (kind 1)
// looks the call id up, tests expiry and PID filter, hashes now_ns XOR task_tag
// with xorshift64 and fires when the hash modulo 1000 is below the rate.
// Every request gives exactly one response: rsp_valid is high for one cycle
// and rsp_data holds the result; that cycle's closing edge is the transfer.
// The receiver cannot stall, so the response is never held.
// Sequence: the lookup walks all table entries through the one read port of
// the rule memory, one entry per cycle. A write then commits in the commit
// state and responds. A check adds a qualify state and, when the rule
// qualifies, the xorshift shift-xor steps, the modulo reduction over every
// hex digit of the hash and a decide state before the response. busy drops
// the cycle after the response; one request is in flight at a time.
// Reset clears all valid bits and the fire counter; rule memory contents
// need no clearing since only valid entries are compared.
`include "assert_macros.svh"

module fault_injection_rule_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fault_chk_pkg::req_type req_data,
   output logic                   rsp_valid,
   output fault_chk_pkg::rsp_type rsp_data
);
   import fault_chk_pkg::*;

   // Sequencer and request registers.
   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   cmp_on_ff, cmp_on_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;

   // Lookup results.
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   entry_type              hit_entry_ff, hit_entry_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;

   // Table valid bits and fire counter.
   logic [RULE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0]             fire_count_ff, fire_count_in;

   // Hash datapath.
   logic [HASH_W-1:0]      mix_ff, mix_in;
   logic [1:0]             step_ff, step_in;
   logic [DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic [DICE_W-1:0]      rem_ff, rem_in;

   // Response register.
   rsp_type                rsp_ff, rsp_in;

   // Rule memory.
   entry_type              entry_mem [RULE_ENTRIES];
   entry_type              rd_entry_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;

   // Decode helpers.
   logic                   scan_done;
   logic                   rule_active;
   logic                   pid_match;
   logic                   key_hit;
   logic [31:0]            req_pid;

   assign scan_done = (scan_idx_ff == CNT_W'(RULE_ENTRIES));
   assign req_pid   = req_ff.task_tag[PID_LSB +: 32];
   assign key_hit   = cmp_on_ff && valid_ff[cmp_idx_ff] &&
                      (rd_entry_ff.key == req_ff.call_id);
   assign rule_active = (hit_entry_ff.expiry == 64'd0) ||
                        !(req_ff.now_ns > hit_entry_ff.expiry);
   assign pid_match   = (hit_entry_ff.pid == 32'd0) || (hit_entry_ff.pid == req_pid);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = (req_ff.kind == KIND_WRITE) ? ST_COMMIT : ST_QUAL;
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_QUAL: begin
            state_in = (hit_ff && rule_active && pid_match) ? ST_MIX : ST_RESP;
         end
         ST_MIX: begin
            if (step_ff == MIX_STEP_C) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (digit_ff == DIGIT_CNT_W'(MIX_DIGITS - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake, response and memory ports.
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      rsp_data  = rsp_ff;
      mem_raddr = scan_idx_ff[IDX_W-1:0];
      mem_we    = (state_ff == ST_COMMIT) && req_ff.rule_present && (hit_ff || free_ff);
      mem_waddr = hit_ff ? hit_idx_ff : free_idx_ff;
      mem_wdata.key    = req_ff.call_id;
      mem_wdata.pid    = req_ff.rule_pid;
      mem_wdata.rate   = req_ff.rule_rate;
      mem_wdata.code   = req_ff.rule_code;
      mem_wdata.expiry = req_ff.rule_expiry_ns;
   end

   // Datapath next values.
   always_comb begin
      rsp_type           idle_rsp;
      logic [HASH_W-1:0] shifted;
      logic [REM_W-1:0]  acc;

      idle_rsp            = '0;
      idle_rsp.fire_total = fire_count_ff;
      shifted             = '0;
      acc                 = '0;

      req_in        = req_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_on_in     = (state_ff == ST_SCAN) && !scan_done;
      cmp_idx_in    = scan_idx_ff[IDX_W-1:0];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      fire_count_in = fire_count_ff;
      mix_in        = mix_ff;
      step_in       = step_ff;
      digit_in      = digit_ff;
      rem_in        = rem_ff;
      rsp_in        = rsp_ff;

      // Compare stage of the table walk, one entry behind the read address.
      if (key_hit && !hit_ff) begin
         hit_in       = 1'b1;
         hit_idx_in   = cmp_idx_ff;
         hit_entry_in = rd_entry_ff;
      end
      if (cmp_on_ff && !valid_ff[cmp_idx_ff] && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = cmp_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         ST_COMMIT: begin
            // Store, replace or remove; a new key in a full table is refused.
            rsp_in = idle_rsp;
            if (req_ff.rule_present) begin
               if (hit_ff || free_ff) valid_in[mem_waddr] = 1'b1;
               else rsp_in.write_status = WSTAT_FULL;
            end else if (hit_ff) begin
               valid_in[hit_idx_ff] = 1'b0;
            end
         end
         ST_QUAL: begin
            rsp_in  = idle_rsp;
            mix_in  = req_ff.now_ns ^ req_ff.task_tag;
            step_in = MIX_STEP_A;
         end
         ST_MIX: begin
            // One shifter serves all three xorshift steps.
            case (step_ff)
               MIX_STEP_A: shifted = mix_ff << MIX_SHL_A;
               MIX_STEP_B: shifted = mix_ff >> MIX_SHR_B;
               default:    shifted = mix_ff << MIX_SHL_C;
            endcase
            mix_in   = mix_ff ^ shifted;
            step_in  = step_ff + 2'd1;
            digit_in = '0;
            rem_in   = '0;
         end
         ST_MOD: begin
            // Fold in the next hex digit and bring the remainder below 1000.
            acc = {rem_ff, {DIGIT_W{1'b0}}} + REM_W'(mix_ff[HASH_W-1 -: DIGIT_W]);
            for (int k = DIGIT_W - 1; k >= 0; k--) begin
               if (acc >= REM_W'(DICE_MOD << k)) acc = acc - REM_W'(DICE_MOD << k);
            end
            rem_in   = acc[DICE_W-1:0];
            mix_in   = mix_ff << DIGIT_W;
            digit_in = digit_ff + DIGIT_CNT_W'(1);
         end
         ST_DECIDE: begin
            rsp_in = idle_rsp;
            if (rem_ff < hit_entry_ff.rate) begin
               fire_count_in        = fire_count_ff + 64'd1;
               rsp_in.fired         = 1'b1;
               rsp_in.error_code    = hit_entry_ff.code;
               rsp_in.event_time_ns = req_ff.now_ns;
               rsp_in.event_pid     = req_pid;
               rsp_in.event_call_id = req_ff.call_id;
               rsp_in.fire_total    = fire_count_ff + 64'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_on_ff     <= 1'b0;
         valid_ff      <= '0;
         fire_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_on_ff     <= cmp_on_in;
         valid_ff      <= valid_in;
         fire_count_ff <= fire_count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      mix_ff       <= mix_in;
      step_ff      <= step_in;
      digit_ff     <= digit_in;
      rem_ff       <= rem_in;
      rsp_ff       <= rsp_in;
   end

   // Rule memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
      rd_entry_ff <= entry_mem[mem_raddr];
   end

   `ASSERT_IMPLY(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_rsp_single_cycle, clock, reset, rsp_valid, !rsp_valid && !busy)
   `ASSERT_NEXT(a_accept_starts_walk, clock, reset, start && !busy, state_ff == ST_SCAN)
   `ASSERT_IMPLY(a_total_tracks, clock, reset, rsp_valid, rsp_data.fire_total == fire_count_ff)
   `ASSERT_NEXT(a_walk_ends, clock, reset, state_ff == ST_SCAN && scan_done, state_ff != ST_SCAN)

endmodule
